FILE: rtl/gge_pkg.sv
`default_nettype none

package gge_pkg;

   // Sizes of the grain table, the snippet store and the window table.
   localparam int GRAIN_COUNT       = 16;
   localparam int GRAIN_BITS        = $clog2(GRAIN_COUNT);
   localparam int SNIPPET_DEPTH     = 65536;
   localparam int SNIP_BITS         = $clog2(SNIPPET_DEPTH);
   localparam int WINDOW_TABLE_SIZE = 256;
   localparam int WIN_BITS          = $clog2(WINDOW_TABLE_SIZE);

   // Fixed-point constants.
   localparam logic [31:0] SEED_RESET = 32'd2463534242;
   localparam logic [23:0] CLOCK_ONE  = 24'd256;
   localparam logic [23:0] PAN_FULL   = 24'hFFFFFF;
   localparam logic [15:0] GAIN_035   = 16'd22938;
   localparam logic [15:0] MIN_GRAIN  = 16'd8;

   // Transaction kinds.
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_STOP = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_FRAMES  = 3'd0;
   localparam logic [2:0] REG_WSTART  = 3'd1;
   localparam logic [2:0] REG_WLENGTH = 3'd2;
   localparam logic [2:0] REG_SPREAD  = 3'd3;
   localparam logic [2:0] REG_GAIN    = 3'd4;
   localparam logic [2:0] REG_SEED    = 3'd5;

   // One entry of the grain memory.
   typedef struct packed {
      logic [31:0] pos;
      logic [15:0] rem;
      logic [15:0] tot;
      logic [23:0] step;
      logic [23:0] pan;
   } grain_type;

   // Status of the window index divider.
   typedef struct packed {
      logic              done;
      logic [WIN_BITS:0] quot;
   } div_stat_type;

   typedef logic [15:0] win_table_type [WINDOW_TABLE_SIZE];

   // Raised-cosine window, sin^2 by an integer polynomial, evaluated at elaboration.
   function automatic win_table_type build_window();
      win_table_type tbl;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   t;
      logic [63:0]   s;
      for (int k = 0; k < WINDOW_TABLE_SIZE; k++) begin
         if (2 * k <= WINDOW_TABLE_SIZE) begin
            x = (64'(2 * k) << 16) / WINDOW_TABLE_SIZE;
         end else begin
            x = (64'(2 * (WINDOW_TABLE_SIZE - k)) << 16) / WINDOW_TABLE_SIZE;
         end
         x2 = (x * x) >> 16;
         t  = (x2 * 64'd307) >> 16;
         t  = 64'd5223 - t;
         t  = (x2 * t) >> 16;
         t  = 64'd42334 - t;
         t  = (x2 * t) >> 16;
         t  = 64'd102944 - t;
         s  = (x * t) >> 16;
         if (s > 64'd65536) begin
            s = 64'd65536;
         end
         tbl[k] = 16'((s * s) >> 17);
      end
      return tbl;
   endfunction

   localparam win_table_type WIN_TABLE = build_window();

   // One step of xorshift32 (13, 17, 5).
   function automatic logic [31:0] xorshift(input logic [31:0] v);
      logic [31:0] s;
      s = v ^ (v << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
      return s;
   endfunction

   // Saturate a wide signed value to 32 bits.
   function automatic logic [31:0] sat32(input logic signed [57:0] v);
      logic [31:0] r;
      if (v > 58'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -58'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gge_div.sv
`default_nettype none

module gge_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [15:0]          elapsed,
   input  wire logic [15:0]          total,
   output gge_pkg::div_stat_type     stat
);
   import gge_pkg::*;

   localparam int STEPS = WIN_BITS + 1;

   logic [16:0]             rem_ff;
   logic [15:0]             den_ff;
   logic [WIN_BITS:0]       quot_ff;
   logic [$clog2(STEPS):0]  cnt_ff;
   logic                    first_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [16:0]             trial;
   logic                    fits;

   // Restoring division of elapsed*WINDOW_TABLE_SIZE by total, one quotient bit a cycle.
   assign trial = first_ff ? rem_ff : {rem_ff[15:0], 1'b0};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == ($clog2(STEPS) + 1)'(STEPS - 1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= {1'b0, elapsed};
         den_ff   <= total;
         quot_ff  <= '0;
         cnt_ff   <= '0;
         first_ff <= 1'b1;
      end else if (busy_ff) begin
         rem_ff   <= fits ? trial - {1'b0, den_ff} : trial;
         quot_ff  <= {quot_ff[WIN_BITS-1:0], fits};
         cnt_ff   <= cnt_ff + 1'b1;
         first_ff <= 1'b0;
      end
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/granular_grain_engine_top.sv
// Sequence: a tick transaction advances the grain clock; when a grain starts, a pan and an offset
// are drawn and the offset steps place it in a free slot. Each grain slot is then read and checked:
// an ended grain is freed, a sounding grain takes two snippet reads and the window index divider,
// then the scaling states and the result register follow; a silent tick goes straight to the result.
// Throughput: one transaction at a time, plus any wait for the previous result to be taken.
// Reset clears the grain active bits, grain clock and control; random state takes the seed.
`default_nettype none

module granular_grain_engine_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [15:0]        req_sample_address,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic [15:0]        req_grain_length,
   input  wire logic [23:0]        req_increment,
   input  wire logic [23:0]        req_interval,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_left,
   output      logic signed [31:0] rsp_right,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import gge_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CLOCK = 5'd1;
   localparam logic [4:0] S_DRAW1 = 5'd2;
   localparam logic [4:0] S_DRAW2 = 5'd3;
   localparam logic [4:0] S_OFF1  = 5'd4;
   localparam logic [4:0] S_OFF2  = 5'd5;
   localparam logic [4:0] S_OFF3  = 5'd6;
   localparam logic [4:0] S_GRD   = 5'd7;
   localparam logic [4:0] S_GCHK  = 5'd8;
   localparam logic [4:0] S_SA    = 5'd9;
   localparam logic [4:0] S_SB    = 5'd10;
   localparam logic [4:0] S_V     = 5'd11;
   localparam logic [4:0] S_DWAIT = 5'd12;
   localparam logic [4:0] S_X     = 5'd13;
   localparam logic [4:0] S_L     = 5'd14;
   localparam logic [4:0] S_R     = 5'd15;
   localparam logic [4:0] S_SC1   = 5'd16;
   localparam logic [4:0] S_SC2   = 5'd17;
   localparam logic [4:0] S_SC3   = 5'd18;
   localparam logic [4:0] S_SC4   = 5'd19;
   localparam logic [4:0] S_EMIT  = 5'd20;

   // Control state.
   logic [4:0]             state_ff, state_in;
   logic [GRAIN_COUNT-1:0] active_ff, active_in;
   logic [23:0]            clock_ff, clock_in;
   logic [31:0]            rnd_ff, rnd_in;
   logic [GRAIN_BITS-1:0]  g_ff, g_in;
   logic [GRAIN_BITS-1:0]  slot_ff, slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [16:0] frames_cfg_ff;
   logic [15:0] wstart_ff;
   logic [16:0] wlength_ff;
   logic [15:0] spread_ff;
   logic [15:0] gain_ff;

   // Datapath registers.
   logic [15:0]        glen_ff;
   logic [23:0]        inc_ff;
   logic [23:0]        iv_ff;
   logic [23:0]        pan_new_ff;
   logic [23:0]        draw_ff;
   logic [39:0]        off1_ff;
   logic [56:0]        off2_ff;
   grain_type          cur_ff;
   logic signed [15:0] a_ff;
   logic signed [33:0] mult_ff;
   logic signed [16:0] v_ff;
   logic [15:0]        w_ff;
   logic signed [17:0] x_ff;
   logic signed [23:0] sum_l_ff;
   logic signed [23:0] sum_r_ff;
   logic signed [40:0] scl_l_ff;
   logic signed [40:0] scl_r_ff;
   logic [31:0]        out_l_ff;
   logic [31:0]        out_r_ff;
   logic [31:0]        rsp_left_ff;
   logic [31:0]        rsp_right_ff;

   // Memories.
   grain_type          grain_mem [GRAIN_COUNT];
   grain_type          gm_q_ff;
   logic               gm_we;
   grain_type          gm_wdata;
   logic [15:0]        sn_mem [SNIPPET_DEPTH];
   logic [15:0]        sn_q_ff;
   logic [SNIP_BITS-1:0] sn_raddr;

   // Helpers.
   logic               req_fire;
   logic               csr_fire;
   logic [16:0]        frames;
   logic               silent;
   logic [24:0]        csum;
   logic               fire_start;
   logic               any_free;
   logic [GRAIN_BITS-1:0] first_free;
   logic               last_grain;
   logic               grain_ends;
   logic [15:0]        tot_eff;
   logic [15:0]        elapsed;
   logic               div_start;
   div_stat_type       div_stat;
   logic [WIN_BITS-1:0] widx;
   logic [33:0]        start_pos;
   logic [33:0]        pos_sum;
   logic [31:0]        pos_new;
   logic [15:0]        rem_new;
   logic [31:0]        seed_val;
   logic signed [16:0] diff;
   logic signed [33:0] v_full;
   logic signed [33:0] x_full;
   logic signed [42:0] pl_full;
   logic signed [42:0] pr_full;
   logic signed [57:0] fin_l;
   logic signed [57:0] fin_r;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // Effective snippet length and silence condition.
   assign frames = (frames_cfg_ff > 17'(SNIPPET_DEPTH)) ? 17'(SNIPPET_DEPTH) : frames_cfg_ff;
   assign silent = (frames == '0) || (wlength_ff <= 17'd1) || (gain_ff == '0);

   // Grain clock advance and start decision.
   assign csum       = {1'b0, clock_ff} + {1'b0, CLOCK_ONE};
   assign fire_start = csum >= {1'b0, iv_ff};

   // First free grain slot.
   always_comb begin
      any_free   = 1'b0;
      first_free = '0;
      for (int i = GRAIN_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            any_free   = 1'b1;
            first_free = GRAIN_BITS'(i);
         end
      end
   end

   assign last_grain = (g_ff == GRAIN_BITS'(GRAIN_COUNT - 1));

   // Grain end check and window index operands from the grain just read.
   assign grain_ends = ({1'b0, gm_q_ff.pos[31:16]} + 17'd1) >= frames;
   assign tot_eff    = (gm_q_ff.tot == '0) ? 16'd1 : gm_q_ff.tot;
   assign elapsed    = (gm_q_ff.rem <= tot_eff) ? tot_eff - gm_q_ff.rem : 16'd0;
   assign div_start  = (state_ff == S_GCHK) && !grain_ends;

   gge_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .elapsed (elapsed),
      .total   (tot_eff),
      .stat    (div_stat)
   );

   assign widx = div_stat.quot[WIN_BITS] ? WIN_BITS'(WINDOW_TABLE_SIZE - 1)
                                         : div_stat.quot[WIN_BITS-1:0];

   // Start position of a new grain, wide enough that the sum cannot wrap.
   assign start_pos = {1'b0, off2_ff[56:24]} + {2'b0, wstart_ff, 16'b0};

   // Position advance and remaining count for write-back.
   assign pos_sum = {2'b0, cur_ff.pos} + {10'b0, cur_ff.step};
   assign pos_new = (pos_sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : pos_sum[31:0];
   assign rem_new = (cur_ff.rem != '0) ? cur_ff.rem - 16'd1 : 16'd0;

   // Arithmetic for the mix.
   assign diff    = $signed({sn_q_ff[15], sn_q_ff}) - $signed({a_ff[15], a_ff});
   assign v_full  = $signed({{18{a_ff[15]}}, a_ff}) + (mult_ff >>> 16);
   assign x_full  = v_ff * $signed({1'b0, w_ff});
   assign pl_full = x_ff * $signed({1'b0, PAN_FULL - cur_ff.pan});
   assign pr_full = x_ff * $signed({1'b0, cur_ff.pan});
   assign fin_l   = (58'(scl_l_ff) * $signed({42'b0, GAIN_035})) >>> 28;
   assign fin_r   = (58'(scl_r_ff) * $signed({42'b0, GAIN_035})) >>> 28;

   assign seed_val = (csr_data == '0) ? SEED_RESET : csr_data;

   // Sequencer for one transaction.
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      clock_in     = clock_ff;
      rnd_in       = rnd_ff;
      g_in         = g_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      gm_we        = 1'b0;
      gm_wdata     = cur_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_STOP: active_in = '0;
                  KIND_TICK: state_in = silent ? S_EMIT : S_CLOCK;
                  default: ;
               endcase
            end
         end
         S_CLOCK: begin
            g_in = '0;
            if (fire_start) begin
               clock_in = 24'(csum - {1'b0, iv_ff});
               if (any_free) begin
                  slot_in  = first_free;
                  state_in = S_DRAW1;
               end else begin
                  state_in = S_GRD;
               end
            end else begin
               clock_in = csum[23:0];
               state_in = S_GRD;
            end
         end
         S_DRAW1: begin
            rnd_in   = xorshift(rnd_ff);
            state_in = S_DRAW2;
         end
         S_DRAW2: begin
            rnd_in   = xorshift(rnd_ff);
            state_in = S_OFF1;
         end
         S_OFF1: state_in = S_OFF2;
         S_OFF2: state_in = S_OFF3;
         S_OFF3: begin
            gm_we         = 1'b1;
            gm_wdata.pos  = (start_pos > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : start_pos[31:0];
            gm_wdata.rem  = glen_ff;
            gm_wdata.tot  = glen_ff;
            gm_wdata.step = inc_ff;
            gm_wdata.pan  = pan_new_ff;
            active_in[slot_ff] = 1'b1;
            state_in      = S_GRD;
         end
         S_GRD: begin
            if (active_ff[g_ff]) begin
               state_in = S_GCHK;
            end else if (last_grain) begin
               state_in = S_SC1;
            end else begin
               g_in = g_ff + 1'b1;
            end
         end
         S_GCHK: begin
            if (grain_ends) begin
               active_in[g_ff] = 1'b0;
               if (last_grain) begin
                  state_in = S_SC1;
               end else begin
                  g_in     = g_ff + 1'b1;
                  state_in = S_GRD;
               end
            end else begin
               state_in = S_SA;
            end
         end
         S_SA: state_in = S_SB;
         S_SB: state_in = S_V;
         S_V: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_stat.done) begin
               state_in = S_X;
            end
         end
         S_X: state_in = S_L;
         S_L: state_in = S_R;
         S_R: begin
            gm_we        = 1'b1;
            gm_wdata.pos = pos_new;
            gm_wdata.rem = rem_new;
            active_in[g_ff] = (rem_new != '0);
            if (last_grain) begin
               state_in = S_SC1;
            end else begin
               g_in     = g_ff + 1'b1;
               state_in = S_GRD;
            end
         end
         S_SC1: state_in = S_SC2;
         S_SC2: state_in = S_SC3;
         S_SC3: state_in = S_SC4;
         S_SC4: state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_fire && csr_index == REG_SEED) begin
         rnd_in = seed_val;
      end
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         clock_ff      <= '0;
         rnd_ff        <= SEED_RESET;
         g_ff          <= '0;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         frames_cfg_ff <= '0;
         wstart_ff     <= '0;
         wlength_ff    <= '0;
         spread_ff     <= 16'd16384;
         gain_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         clock_ff     <= clock_in;
         rnd_ff       <= rnd_in;
         g_ff         <= g_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_fire) begin
            case (csr_index)
               REG_FRAMES:  frames_cfg_ff <= csr_data[16:0];
               REG_WSTART:  wstart_ff     <= csr_data[15:0];
               REG_WLENGTH: wlength_ff    <= csr_data[16:0];
               REG_SPREAD:  spread_ff     <= csr_data[15:0];
               REG_GAIN:    gain_ff       <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers, at most one multiplication per state.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               glen_ff  <= (req_grain_length < MIN_GRAIN) ? MIN_GRAIN : req_grain_length;
               inc_ff   <= req_increment;
               iv_ff    <= (req_interval < CLOCK_ONE) ? CLOCK_ONE : req_interval;
               sum_l_ff <= '0;
               sum_r_ff <= '0;
               out_l_ff <= '0;
               out_r_ff <= '0;
            end
         end
         S_DRAW1: pan_new_ff <= rnd_in[23:0];
         S_DRAW2: draw_ff    <= rnd_in[23:0];
         S_OFF1:  off1_ff    <= {16'b0, draw_ff} * {24'b0, spread_ff};
         S_OFF2:  off2_ff    <= {17'b0, off1_ff} * {40'b0, wlength_ff};
         S_GCHK:  cur_ff     <= gm_q_ff;
         S_SA:    a_ff       <= sn_q_ff;
         S_SB:    mult_ff    <= diff * $signed({1'b0, cur_ff.pos[15:0]});
         S_V:     v_ff       <= v_full[16:0];
         S_DWAIT: w_ff       <= WIN_TABLE[widx];
         S_X:     x_ff       <= x_full[32:15];
         S_L:     sum_l_ff   <= sum_l_ff + 24'(pl_full >>> 24);
         S_R:     sum_r_ff   <= sum_r_ff + 24'(pr_full >>> 24);
         S_SC1:   scl_l_ff   <= sum_l_ff * $signed({1'b0, gain_ff});
         S_SC2:   scl_r_ff   <= sum_r_ff * $signed({1'b0, gain_ff});
         S_SC3:   out_l_ff   <= sat32(fin_l);
         S_SC4:   out_r_ff   <= sat32(fin_r);
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_left_ff  <= out_l_ff;
               rsp_right_ff <= out_r_ff;
            end
         end
         default: ;
      endcase
   end

   // Grain memory: one write port, registered read at the grain counter.
   always_ff @(posedge clock) begin
      if (gm_we) begin
         grain_mem[(state_ff == S_OFF3) ? slot_ff : g_ff] <= gm_wdata;
      end
      gm_q_ff <= grain_mem[g_ff];
   end

   // Snippet memory: load transactions write, the grain walk reads two neighbors.
   assign sn_raddr = (state_ff == S_SA) ? cur_ff.pos[31:16] + 1'b1 : gm_q_ff.pos[31:16];

   always_ff @(posedge clock) begin
      if (req_fire && req_kind == KIND_LOAD) begin
         sn_mem[req_sample_address] <= req_sample_value;
      end
      sn_q_ff <= sn_mem[sn_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = rsp_left_ff;
   assign rsp_right = rsp_right_ff;

   // Reset leaves no grain running and the sequencer idle.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (active_ff == '0 && state_ff == S_IDLE))
      else $error("grains or sequencer not cleared by reset");

   // A stop transaction ends every grain.
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == KIND_STOP) |=> (active_ff == '0))
      else $error("stop transaction left a grain active");

   // A new grain is only placed in a free slot.
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OFF3) |-> !active_ff[slot_ff])
      else $error("grain started over an active slot");

endmodule

`default_nettype wire
